// ===== design/gzn_pkg.sv =====
// gzn_pkg: widths, types and constants shared by the group z-score normalizer
// used by gzn_unit and group_zscore_normalizer; no other dependencies
`default_nettype none

package gzn_pkg;

  // samples per group
  localparam int N = 5;
  // sample and result width
  localparam int XBITS = 16;
  // index into the sample store
  localparam int IW = $clog2(N);
  // running sum of samples
  localparam int SUMW = XBITS + $clog2(N);
  // scaled deviation N*x - sum: signed width and magnitude width
  localparam int DW = XBITS + 1 + $clog2(N);
  localparam int DM = DW - 1;
  // squared deviation and sum of squares
  localparam int SQW = 2 * DM;
  localparam int SW = SQW + $clog2(N);
  // radicand of the root step (sum of squares times 2^16)
  localparam int UW = SW + 16;
  // root width and radicand width
  localparam int RW = (UW + 1) / 2;
  localparam int RADW = 2 * RW;
  // dividend of one normalize step: |D| * 2^20 + R/2
  localparam int NDW = DM + 21;
  // shared unit operand register and partial remainder widths;
  // the scaled root keeps a remainder below 8*N*2^RW
  localparam int XW0 = (UW > RADW) ? UW : RADW;
  localparam int XW = (XW0 > NDW) ? XW0 : NDW;
  localparam int AW = RW + 3 + $clog2(N);
  localparam int CNTW = $clog2(XW + 1);

  // saturation limits of the Q4.12 result
  localparam logic [XW-1:0] SAT_POS = XW'(32767);
  localparam logic [XW-1:0] SAT_NEG_MAG = XW'(32768);

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } op_t;

  // request to the shared divide / square root unit
  typedef struct packed {
    logic            go;
    op_t             op;
    logic [CNTW-1:0] steps;
  } req_t;

endpackage

`default_nettype wire

// ===== design/gzn_unit.sv =====
// gzn_unit: shared bit-serial restoring divider and scaled binary square root
// (largest r with N*r*r <= operand); depends on gzn_pkg for widths and request
`default_nettype none

module gzn_unit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire gzn_pkg::req_t           req,
  input  wire logic [gzn_pkg::XW-1:0]  operand,
  input  wire logic [gzn_pkg::RW-1:0]  divisor,
  output logic                         done,
  output logic [gzn_pkg::XW-1:0]       q
);

  logic                      running;
  logic [gzn_pkg::CNTW-1:0]  cnt;
  gzn_pkg::op_t              op;
  logic [gzn_pkg::XW-1:0]    x;
  logic [gzn_pkg::AW-1:0]    rem;
  logic [gzn_pkg::AW-1:0]    rem_sh;
  logic [gzn_pkg::AW-1:0]    trial;
  logic                      ge;

  // one digit step: shift in the next operand bits, compare, subtract
  // root trial is N*(4r+1), the growth of N*r*r when r gains a one bit
  always_comb begin
    if (op == gzn_pkg::OP_SQRT) begin
      rem_sh = {rem[gzn_pkg::AW-3:0], x[gzn_pkg::XW-1:gzn_pkg::XW-2]};
      trial  = gzn_pkg::AW'(gzn_pkg::N) * gzn_pkg::AW'({q[gzn_pkg::RW-1:0], 2'b01});
    end else begin
      rem_sh = {rem[gzn_pkg::AW-2:0], x[gzn_pkg::XW-1]};
      trial  = gzn_pkg::AW'(divisor);
    end
    ge = (rem_sh >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        cnt     <= req.steps;
      end else if (running) begin
        cnt <= cnt - gzn_pkg::CNTW'(1);
        if (cnt == gzn_pkg::CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      op  <= req.op;
      x   <= operand;
      rem <= '0;
      q   <= '0;
    end else if (running) begin
      rem <= ge ? (rem_sh - trial) : rem_sh;
      q   <= {q[gzn_pkg::XW-2:0], ge};
      if (op == gzn_pkg::OP_SQRT) begin
        x <= x << 2;
      end else begin
        x <= x << 1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/group_zscore_normalizer.sv =====
// group z-score normalizer: loads one item per cycle while idle; after the last
// sample it is busy with N sum and 2N deviation steps, one scaled root on the
// shared bit-serial unit, then N divides; each result strobes the cycle after
// its divide, the last in the first idle cycle; the receiver cannot stall.
// all-equal groups skip the root and the divides. synchronous reset empties
// the group and the sequencer.
`default_nettype none

module group_zscore_normalizer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] sample_value,
  output logic                    busy,
  output logic                    out_valid,
  output logic signed [15:0]      norm_value,
  output logic                    last_of_group,
  output logic                    std_was_zero
);

  typedef enum logic [8:0] {
    ST_LOAD = 9'b000000001,
    ST_SUM  = 9'b000000010,
    ST_DEV  = 9'b000000100,
    ST_SQ   = 9'b000001000,
    ST_SQRT = 9'b000010000,
    ST_NDEV = 9'b000100000,
    ST_NGO  = 9'b001000000,
    ST_NDIV = 9'b010000000,
    ST_RAW  = 9'b100000000
  } state_t;

  localparam logic signed [gzn_pkg::DW-1:0] NS = gzn_pkg::DW'(gzn_pkg::N);
  localparam logic [gzn_pkg::IW-1:0] LAST_IDX = gzn_pkg::IW'(gzn_pkg::N - 1);

  state_t                          state;
  logic signed [15:0]              store [gzn_pkg::N];
  logic [gzn_pkg::IW-1:0]          cnt;
  logic [gzn_pkg::IW-1:0]          idx;
  logic signed [gzn_pkg::SUMW-1:0] sum;
  logic [gzn_pkg::SW-1:0]          ssq;
  logic [gzn_pkg::DM-1:0]          dmag;
  logic                            dneg;
  logic [gzn_pkg::RW-1:0]          rroot;
  gzn_pkg::req_t                   req;
  logic [gzn_pkg::XW-1:0]          operand;
  logic [gzn_pkg::RW-1:0]          divisor;
  logic                            unit_done;
  logic [gzn_pkg::XW-1:0]          q;

  logic signed [15:0]              cur;
  logic signed [gzn_pkg::DW-1:0]   d_val;
  logic [gzn_pkg::SQW-1:0]         sq_w;
  logic [gzn_pkg::SW-1:0]          ssq_sum;
  logic [gzn_pkg::NDW-1:0]         nd;

  gzn_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .operand (operand),
    .divisor (divisor),
    .done    (unit_done),
    .q       (q)
  );

  // scaled deviation of the current sample, its square, and next dividend
  always_comb begin
    cur     = store[idx];
    d_val   = gzn_pkg::DW'(cur) * NS - gzn_pkg::DW'(sum);
    sq_w    = gzn_pkg::SQW'(dmag) * gzn_pkg::SQW'(dmag);
    ssq_sum = ssq + gzn_pkg::SW'(sq_w);
    nd      = gzn_pkg::NDW'({dmag, 20'h00000}) + gzn_pkg::NDW'(rroot >> 1);
  end

  assign busy = (state != ST_LOAD);

  // sample store
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && start) begin
      store[cnt] <= sample_value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      idx       <= '0;
      req       <= '0;
      out_valid <= 1'b0;
    end else begin
      req.go    <= 1'b0;
      out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (start) begin
            if (cnt == LAST_IDX) begin
              cnt   <= '0;
              idx   <= '0;
              state <= ST_SUM;
            end else begin
              cnt <= cnt + gzn_pkg::IW'(1);
            end
          end
        end
        ST_SUM: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_DEV;
          end else begin
            idx <= idx + gzn_pkg::IW'(1);
          end
        end
        ST_DEV: begin
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (idx == LAST_IDX) begin
            idx <= '0;
            if (ssq_sum == '0) begin
              state <= ST_RAW;
            end else begin
              req.go    <= 1'b1;
              req.op    <= gzn_pkg::OP_SQRT;
              req.steps <= gzn_pkg::CNTW'(gzn_pkg::RW);
              state     <= ST_SQRT;
            end
          end else begin
            idx   <= idx + gzn_pkg::IW'(1);
            state <= ST_DEV;
          end
        end
        ST_SQRT: begin
          if (unit_done) begin
            idx   <= '0;
            state <= ST_NDEV;
          end
        end
        ST_NDEV: begin
          state <= ST_NGO;
        end
        ST_NGO: begin
          req.go    <= 1'b1;
          req.op    <= gzn_pkg::OP_DIV;
          req.steps <= gzn_pkg::CNTW'(gzn_pkg::NDW);
          state     <= ST_NDIV;
        end
        ST_NDIV: begin
          if (unit_done) begin
            out_valid <= 1'b1;
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_LOAD;
            end else begin
              idx   <= idx + gzn_pkg::IW'(1);
              state <= ST_NDEV;
            end
          end
        end
        ST_RAW: begin
          out_valid <= 1'b1;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_LOAD;
          end else begin
            idx <= idx + gzn_pkg::IW'(1);
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        sum <= '0;
        ssq <= '0;
      end
      ST_SUM: begin
        sum <= sum + gzn_pkg::SUMW'(cur);
      end
      ST_DEV, ST_NDEV: begin
        dneg <= d_val[gzn_pkg::DW-1];
        dmag <= d_val[gzn_pkg::DW-1] ? gzn_pkg::DM'(-d_val) : gzn_pkg::DM'(d_val);
      end
      ST_SQ: begin
        ssq <= ssq_sum;
        // radicand S * 2^16, aligned to the top of the operand register
        if (idx == LAST_IDX) begin
          operand <= gzn_pkg::XW'({ssq_sum, 16'h0000}) << (gzn_pkg::XW - gzn_pkg::RADW);
        end
      end
      ST_SQRT: begin
        rroot <= q[gzn_pkg::RW-1:0];
      end
      ST_NGO: begin
        operand <= gzn_pkg::XW'(nd) << (gzn_pkg::XW - gzn_pkg::NDW);
        divisor <= rroot;
      end
      default: begin
      end
    endcase
  end

  // result registers, saturated to the Q4.12 range
  always_ff @(posedge clk) begin
    if (state == ST_NDIV && unit_done) begin
      last_of_group <= (idx == LAST_IDX);
      std_was_zero  <= 1'b0;
      if (dneg) begin
        if (q > gzn_pkg::SAT_NEG_MAG) begin
          norm_value <= 16'sh8000;
        end else begin
          norm_value <= 16'(17'd0 - q[16:0]);
        end
      end else begin
        if (q > gzn_pkg::SAT_POS) begin
          norm_value <= 16'sh7fff;
        end else begin
          norm_value <= q[15:0];
        end
      end
    end else if (state == ST_RAW) begin
      last_of_group <= (idx == LAST_IDX);
      std_was_zero  <= 1'b1;
      norm_value    <= cur;
    end
  end

endmodule

`default_nettype wire
